// ----- src/kpu_pkg.sv -----
// Package for the permutation unranking block: field widths, command and
// status structs, and saturated factorial helpers used at elaboration.
// No dependencies.
package kpu_pkg;

    localparam int SIZE_W  = 4;
    localparam int RANK_W  = 19;
    localparam int DIGIT_W = 4;
    // One bit above the rank width, so a saturated constant always exceeds any rank.
    localparam int SAT_W   = RANK_W + 1;
    localparam logic [SAT_W-1:0] SAT_MAX = {SAT_W{1'b1}};

    typedef struct packed {
        logic load;
        logic step;
    } cmd_t;

    typedef struct packed {
        logic last;
    } stat_t;

    // Factorial of m, saturated to SAT_W bits
    function automatic logic [SAT_W-1:0] sat_fact(input int m);
        longint f;
        f = 1;
        for (int i = 2; i <= m; i++)
        begin
            f = f * i;
            if (f > longint'(SAT_MAX))
            begin
                f = longint'(SAT_MAX);
            end
        end
        return SAT_W'(f);
    endfunction

    // j times m factorial, saturated; j above m never reaches a rank
    function automatic logic [SAT_W-1:0] sat_mult(input int m, input int j);
        longint v;
        if (j > m)
        begin
            v = longint'(SAT_MAX);
        end
        else
        begin
            v = longint'(sat_fact(m)) * j;
            if (v > longint'(SAT_MAX))
            begin
                v = longint'(SAT_MAX);
            end
        end
        return SAT_W'(v);
    endfunction

endpackage

// ----- src/kpu_if.sv -----
// Handshake channels of the permutation unranking block: input word and
// result word, each with valid, ready and payload. Depends on kpu_pkg.
interface kpu_in_if;
    logic                        valid;
    logic                        ready;
    logic [kpu_pkg::SIZE_W-1:0]  size_n;
    logic [kpu_pkg::RANK_W-1:0]  rank_k;

    modport source (output valid, output size_n, output rank_k, input ready);
    modport sink   (input valid, input size_n, input rank_k, output ready);
endinterface

interface kpu_out_if;
    logic                        valid;
    logic                        ready;
    logic [kpu_pkg::DIGIT_W-1:0] digit;
    logic                        last;
    logic                        error;

    modport source (output valid, output digit, output last, output error, input ready);
    modport sink   (input valid, input digit, input last, input error, output ready);
endinterface

// ----- src/kth_permutation_unrank.sv -----
// An accepted input word loads the rank, symbol pool and place counter; each
// step then forms one digit into the result register, n digits for a word of
// size n at one digit a cycle while the result register is free, and a single
// word for an error word; the next word is taken as the final digit is formed.
// Reset (rst_n, asynchronous, active low) clears the controller and error flag.
// Top level of the permutation unranking block; depends on kpu_pkg, kpu_if,
// kpu_ctrl and kpu_datapath.
module kth_permutation_unrank #(
    parameter int MAX_N = 9
) (
    input  logic      clk,
    input  logic      rst_n,
    kpu_in_if.sink    in_ch,
    kpu_out_if.source out_ch
);

    kpu_pkg::cmd_t  cmd;
    kpu_pkg::stat_t stat;

    // Sequence words and pace the result register
    kpu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    // Decode rank place by place
    kpu_datapath #(
        .MAX_N (MAX_N)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .stat   (stat),
        .size_n (in_ch.size_n),
        .rank_k (in_ch.rank_k),
        .digit  (out_ch.digit),
        .last   (out_ch.last),
        .error  (out_ch.error)
    );

endmodule

// ----- src/kpu_datapath.sv -----
// Datapath of the permutation unranking block: remaining rank, symbol pool,
// place counter and result register. Depends on kpu_pkg.
module kpu_datapath #(
    parameter int MAX_N = 9
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  kpu_pkg::cmd_t               cmd,
    output kpu_pkg::stat_t              stat,
    input  logic [kpu_pkg::SIZE_W-1:0]  size_n,
    input  logic [kpu_pkg::RANK_W-1:0]  rank_k,
    output logic [kpu_pkg::DIGIT_W-1:0] digit,
    output logic                        last,
    output logic                        error
);

    localparam int SW = kpu_pkg::SIZE_W;
    localparam int RW = kpu_pkg::RANK_W;
    localparam int DW = kpu_pkg::DIGIT_W;
    localparam int TW = kpu_pkg::SAT_W;
    localparam int FACT_DEPTH = 2 ** SW;

    logic [RW-1:0] k_reg, k_next;
    logic [SW-1:0] left_reg, left_next;
    logic          err_reg, err_next;
    logic [DW-1:0] pool_reg [MAX_N];
    logic [DW-1:0] pool_next [MAX_N];
    logic [DW-1:0] digit_reg, digit_next;
    logic          last_reg, last_next;
    logic          error_reg, error_next;

    logic [TW-1:0] fact_tab [FACT_DEPTH];
    logic [TW-1:0] mult_tab [MAX_N][MAX_N];
    logic [TW-1:0] row [MAX_N];
    logic [MAX_N-1:0] thr;
    logic [SW-1:0] sel;
    logic [TW-1:0] sub;
    logic [DW-1:0] pick;
    logic          in_ok;
    logic          place_last;

    // Build constant tables of saturated factorials and their multiples
    for (genvar i = 0; i < FACT_DEPTH; i++)
    begin : g_fact
        localparam logic [TW-1:0] FV = kpu_pkg::sat_fact(i);
        assign fact_tab[i] = FV;
    end

    for (genvar m = 0; m < MAX_N; m++)
    begin : g_row
        for (genvar j = 0; j < MAX_N; j++)
        begin : g_col
            localparam logic [TW-1:0] MV = kpu_pkg::sat_mult(m, j);
            assign mult_tab[m][j] = MV;
        end
    end

    // Check the incoming size and rank
    assign in_ok = (size_n != '0) && (size_n <= SW'(MAX_N)) && (rank_k != '0) &&
                   ({1'b0, rank_k} <= fact_tab[size_n]);

    // Pick the multiples of (left-1)! for the current place
    always_comb
    begin
        for (int j = 0; j < MAX_N; j++)
        begin
            row[j] = kpu_pkg::SAT_MAX;
        end
        for (int m = 0; m < MAX_N; m++)
        begin
            if (left_reg == SW'(m + 1))
            begin
                row = mult_tab[m];
            end
        end
    end

    // Count the multiples not above the rank: that is the selector
    always_comb
    begin
        thr = '0;
        sel = '0;
        for (int j = 1; j < MAX_N; j++)
        begin
            thr[j] = ({1'b0, k_reg} >= row[j]);
        end
        for (int j = 1; j < MAX_N; j++)
        begin
            if (thr[j])
            begin
                sel = sel + SW'(1);
            end
        end
    end

    // Select the symbol and the amount to take off the rank
    always_comb
    begin
        pick = pool_reg[0];
        sub  = '0;
        for (int p = 0; p < MAX_N; p++)
        begin
            if (sel == SW'(p))
            begin
                pick = pool_reg[p];
                sub  = row[p];
            end
        end
        if (sel == '0)
        begin
            sub = '0;
        end
    end

    assign place_last = err_reg || (left_reg == SW'(1));

    // Load a new word or advance one place
    always_comb
    begin
        k_next     = k_reg;
        left_next  = left_reg;
        err_next   = err_reg;
        pool_next  = pool_reg;
        digit_next = digit_reg;
        last_next  = last_reg;
        error_next = error_reg;
        if (cmd.step)
        begin
            k_next    = k_reg - sub[RW-1:0];
            left_next = left_reg - SW'(1);
            for (int p = 0; p < MAX_N - 1; p++)
            begin
                if (SW'(p) >= sel)
                begin
                    pool_next[p] = pool_reg[p + 1];
                end
            end
            digit_next = err_reg ? '0 : pick;
            last_next  = place_last;
            error_next = err_reg;
        end
        if (cmd.load)
        begin
            k_next    = rank_k - RW'(1);
            left_next = size_n;
            err_next  = !in_ok;
            for (int p = 0; p < MAX_N; p++)
            begin
                pool_next[p] = DW'(p + 1);
            end
        end
    end

    // Hold the control flag under reset; payload needs none
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_reg <= 1'b0;
        end
        else
        begin
            err_reg <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg     <= k_next;
        left_reg  <= left_next;
        pool_reg  <= pool_next;
        digit_reg <= digit_next;
        last_reg  <= last_next;
        error_reg <= error_next;
    end

    assign stat.last = place_last;
    assign digit     = digit_reg;
    assign last      = last_reg;
    assign error     = error_reg;

    // An error word goes out as one final word with digit zero
    a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && !cmd.load && err_reg) |=> (error_reg && last_reg && digit_reg == '0))
        else $error("error word malformed");

    // A valid place never steps with the place counter at zero
    a_left_live: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && !err_reg) |-> (left_reg != '0))
        else $error("step with no place left");

    // The selector always lands on one of the unused symbols
    a_sel_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && !err_reg) |-> (sel < left_reg))
        else $error("selector past the unused symbols");

endmodule

// ----- src/kpu_ctrl.sv -----
// Controller of the permutation unranking block: accepts input words, paces
// one place per cycle into the result register while it is free. Depends on kpu_pkg.
module kpu_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    output kpu_pkg::cmd_t  cmd,
    input  kpu_pkg::stat_t stat
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;

    logic state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic slot_free;
    logic step;
    logic done;
    logic load;

    // Step when the result register is empty or being drained
    assign slot_free = !out_valid_reg || out_ready;
    assign step      = (state_reg == S_RUN) && slot_free;
    assign done      = step && stat.last;
    assign in_ready  = (state_reg == S_IDLE) || done;
    assign load      = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (load)
                begin
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                if (load)
                begin
                    state_next = S_RUN;
                end
                else if (done)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Fill the result register on a step, drop it once taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign cmd.load  = load;
    assign cmd.step  = step;
    assign out_valid = out_valid_reg;

    // Ready while running only on the final place
    a_ready_run: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ready && state_reg == S_RUN) |-> (step && stat.last))
        else $error("input ready mid permutation");

    // An accepted word always leaves the block running
    a_load_run: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (state_reg == S_RUN))
        else $error("accepted word not started");

    // A result appears only after a step
    a_rise_step: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(step))
        else $error("result without step");

endmodule
